>>> hw/rtl/salru_pkg.sv
// Shared types, constants and codes of the set-associative LRU cache model.
`default_nettype none

package salru_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned DEF_MAX_SETS   = 64;
  localparam int unsigned DEF_MAX_WAYS   = 8;
  localparam int unsigned DEF_ADDR_WIDTH = 64;

  // Fixed field widths.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned AGE_W      = 8;
  localparam int unsigned SETB_W     = 3;
  localparam int unsigned WAYSR_W    = 4;
  localparam int unsigned BLKB_W     = 6;
  localparam int unsigned SB_W       = 4;
  localparam int unsigned SHIFT_W    = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // Register reset values.
  localparam logic [SETB_W-1:0]  SET_BITS_RST   = 3'd4;
  localparam logic [WAYSR_W-1:0] WAYS_RST       = 4'd1;
  localparam logic [BLKB_W-1:0]  BLOCK_BITS_RST = 6'd4;

  // Access commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_WAYS_IN_USE = 2'd1,
    CFG_BLOCK_BITS  = 2'd2
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SECOND
  } state_e;

  // One input item.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
  } in_t;

  // One result item.
  typedef struct packed {
    logic             hit;
    logic             miss;
    logic             eviction;
    logic             last;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } out_t;

  // Lookup outcome handed from the lookup unit to the sequencer.
  typedef struct packed {
    logic hit;
    logic evict;
  } lk_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/set_assoc_lru_cache_sim.sv
// Top level of the set-associative LRU cache model: sequencer, counters and result register.
//
// Each accepted command reads the ways of one set from on-chip memory, updates tags, valid
// bits and LRU ages, and writes the set back. A load or store does a synchronous set read, then
// compare and write-back, before the next command is accepted. A modify also makes a second
// result, and that result always hits the line that the first access
// left most recent, so it changes no stored state and needs no second memory read. Command
// code 3 is accepted and ignored. Results appear on res_o for exactly one cycle, marked by
// res_valid_o, starting at the same clock edge that writes their set back; the second result
// of a modify follows in the very next cycle. The receiver cannot stall results. No clearing
// pass follows reset: per-set valid flops make every way free at once. Configuration writes
// are always taken (cfg_ready_o is tied high) and must only be issued while the block is idle.
`default_nettype none

module set_assoc_lru_cache_sim
  import salru_pkg::*;
#(
  parameter int unsigned MAX_SETS   = DEF_MAX_SETS,
  parameter int unsigned MAX_WAYS   = DEF_MAX_WAYS,
  parameter int unsigned ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_t                   in_i,
  output logic                       res_valid_o,
  output out_t                       res_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SET_MSB = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned IDX_W   = (SET_MSB > 0) ? SET_MSB : 1;
  localparam int unsigned ROWS    = 1 << SET_MSB;

  state_e                         state_q, state_d;
  logic [SETB_W-1:0]              set_bits_q;
  logic [WAYSR_W-1:0]             ways_q;
  logic [BLKB_W-1:0]              block_bits_q;
  logic [CNT_W-1:0]               hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]               miss_cnt_q, miss_cnt_d;
  logic [CNT_W-1:0]               ev_cnt_q, ev_cnt_d;
  logic                           res_valid_q, res_valid_d;
  out_t                           res_q, res_d;
  logic [ADDR_WIDTH-1:0]          tag_q;
  logic [IDX_W-1:0]               set_q;
  logic                           mod_q;

  logic                           accept;
  logic                           cmd_ok;
  logic                           item_go;
  logic [ADDR_WIDTH-1:0]          addr_m;
  logic [ADDR_WIDTH-1:0]          set_sh;
  logic [SB_W-1:0]                sb_eff;
  logic [IDX_W-1:0]               idx_mask;
  logic [IDX_W-1:0]               set_idx;
  logic [SHIFT_W-1:0]             tag_shift;
  logic [ADDR_WIDTH-1:0]          tag_new;
  logic                           mem_rd_en;
  logic                           mem_wr_en;
  lk_status_t                     lk_status;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tags, wr_tags;
  logic [MAX_WAYS-1:0]                 rd_valid, wr_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0]      rd_age, wr_age;

  // Input transfer.
  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign cmd_ok  = in_i.command inside {CMD_LOAD, CMD_STORE, CMD_MODIFY};
  assign item_go = accept && cmd_ok;

  // Set index and tag of the incoming address.
  assign addr_m    = in_i.address[ADDR_WIDTH-1:0];
  assign sb_eff    = (SB_W'(set_bits_q) > SB_W'(SET_MSB)) ? SB_W'(SET_MSB) : SB_W'(set_bits_q);
  assign set_sh    = addr_m >> block_bits_q;
  assign idx_mask  = ~({IDX_W{1'b1}} << sb_eff);
  assign set_idx   = set_sh[IDX_W-1:0] & idx_mask;
  assign tag_shift = SHIFT_W'(block_bits_q) + SHIFT_W'(sb_eff);
  assign tag_new   = addr_m >> tag_shift;

  salru_mem #(
    .ROWS  (ROWS),
    .IDX_W (IDX_W),
    .WAYS  (MAX_WAYS),
    .TAG_W (ADDR_WIDTH)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (mem_rd_en),
    .rd_idx_i   (set_idx),
    .wr_en_i    (mem_wr_en),
    .wr_idx_i   (set_q),
    .wr_tags_i  (wr_tags),
    .wr_valid_i (wr_valid),
    .wr_age_i   (wr_age),
    .rd_tags_o  (rd_tags),
    .rd_valid_o (rd_valid),
    .rd_age_o   (rd_age)
  );

  salru_lookup #(
    .WAYS  (MAX_WAYS),
    .TAG_W (ADDR_WIDTH)
  ) u_lookup (
    .ways_cfg_i (ways_q),
    .tag_i      (tag_q),
    .rd_tags_i  (rd_tags),
    .rd_valid_i (rd_valid),
    .rd_age_i   (rd_age),
    .status_o   (lk_status),
    .wr_tags_o  (wr_tags),
    .wr_valid_o (wr_valid),
    .wr_age_o   (wr_age)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_go) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = mod_q ? ST_SECOND : ST_IDLE;
      end
      ST_SECOND: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory control, counters and result.
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_wr_en   = 1'b0;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    ev_cnt_d    = ev_cnt_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      ST_IDLE: begin
        mem_rd_en = item_go;
      end
      ST_LOOKUP: begin
        mem_wr_en   = 1'b1;
        res_valid_d = 1'b1;
        if (lk_status.hit) begin
          if (hit_cnt_q != '1) begin
            hit_cnt_d = hit_cnt_q + CNT_W'(1);
          end
        end else begin
          if (miss_cnt_q != '1) begin
            miss_cnt_d = miss_cnt_q + CNT_W'(1);
          end
          if (lk_status.evict && (ev_cnt_q != '1)) begin
            ev_cnt_d = ev_cnt_q + CNT_W'(1);
          end
        end
        res_d.hit            = lk_status.hit;
        res_d.miss           = !lk_status.hit;
        res_d.eviction       = lk_status.evict;
        res_d.last           = !mod_q;
        res_d.hit_total      = hit_cnt_d;
        res_d.miss_total     = miss_cnt_d;
        res_d.eviction_total = ev_cnt_d;
      end
      ST_SECOND: begin
        // The store half of a modify hits the line the load half just touched.
        res_valid_d = 1'b1;
        if (hit_cnt_q != '1) begin
          hit_cnt_d = hit_cnt_q + CNT_W'(1);
        end
        res_d.hit            = 1'b1;
        res_d.miss           = 1'b0;
        res_d.eviction       = 1'b0;
        res_d.last           = 1'b1;
        res_d.hit_total      = hit_cnt_d;
        res_d.miss_total     = miss_cnt_q;
        res_d.eviction_total = ev_cnt_q;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hit_cnt_q    <= '0;
      miss_cnt_q   <= '0;
      ev_cnt_q     <= '0;
      res_valid_q  <= 1'b0;
      set_bits_q   <= SET_BITS_RST;
      ways_q       <= WAYS_RST;
      block_bits_q <= BLOCK_BITS_RST;
    end else begin
      state_q     <= state_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      ev_cnt_q    <= ev_cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SET_BITS:    set_bits_q   <= cfg_data_i[SETB_W-1:0];
          CFG_WAYS_IN_USE: ways_q       <= cfg_data_i[WAYSR_W-1:0];
          CFG_BLOCK_BITS:  block_bits_q <= cfg_data_i[BLKB_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (item_go) begin
      tag_q <= tag_new;
      set_q <= set_idx;
      mod_q <= (in_i.command == CMD_MODIFY);
    end
    res_q <= res_d;
  end

  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> hw/rtl/salru_mem.sv
// Set memories: one row of tags and one row of valid/age state per set.
`default_nettype none

module salru_mem
  import salru_pkg::*;
#(
  parameter int unsigned ROWS  = 64,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned WAYS  = 8,
  parameter int unsigned TAG_W = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            rd_en_i,
  input  wire logic [IDX_W-1:0]                rd_idx_i,
  input  wire logic                            wr_en_i,
  input  wire logic [IDX_W-1:0]                wr_idx_i,
  input  wire logic [WAYS-1:0][TAG_W-1:0]      wr_tags_i,
  input  wire logic [WAYS-1:0]                 wr_valid_i,
  input  wire logic [WAYS-1:0][AGE_W-1:0]      wr_age_i,
  output logic      [WAYS-1:0][TAG_W-1:0]      rd_tags_o,
  output logic      [WAYS-1:0]                 rd_valid_o,
  output logic      [WAYS-1:0][AGE_W-1:0]      rd_age_o
);

  // Tag rows are undefined until written; state rows are qualified by a row-valid bit.
  logic [WAYS-1:0][TAG_W-1:0] tag_mem [ROWS];
  logic [WAYS-1:0][AGE_W:0]   meta_mem [ROWS];

  logic [ROWS-1:0]            row_valid_q;
  logic                       rd_row_valid_q;
  logic [WAYS-1:0][TAG_W-1:0] rd_tags_q;
  logic [WAYS-1:0][AGE_W:0]   rd_meta_q;

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_mem[wr_idx_i] <= wr_tags_i;
      for (int w = 0; w < WAYS; w++) begin
        meta_mem[wr_idx_i][w] <= {wr_valid_i[w], wr_age_i[w]};
      end
    end
    if (rd_en_i) begin
      rd_tags_q <= tag_mem[rd_idx_i];
      rd_meta_q <= meta_mem[rd_idx_i];
    end
  end

  // Row-valid bits: a row that was never written reads as all ways free, age zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q    <= '0;
      rd_row_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_row_valid_q <= row_valid_q[rd_idx_i];
      end
    end
  end

  // Unpack the state row.
  always_comb begin
    rd_tags_o = rd_tags_q;
    for (int w = 0; w < WAYS; w++) begin
      rd_valid_o[w] = rd_row_valid_q & rd_meta_q[w][AGE_W];
      rd_age_o[w]   = rd_row_valid_q ? rd_meta_q[w][AGE_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/salru_lookup.sv
// Tag compare, victim choice and LRU age update for one set.
`default_nettype none

module salru_lookup
  import salru_pkg::*;
#(
  parameter int unsigned WAYS  = 8,
  parameter int unsigned TAG_W = 64
) (
  input  wire logic [WAYSR_W-1:0]             ways_cfg_i,
  input  wire logic [TAG_W-1:0]               tag_i,
  input  wire logic [WAYS-1:0][TAG_W-1:0]     rd_tags_i,
  input  wire logic [WAYS-1:0]                rd_valid_i,
  input  wire logic [WAYS-1:0][AGE_W-1:0]     rd_age_i,
  output lk_status_t                          status_o,
  output logic      [WAYS-1:0][TAG_W-1:0]     wr_tags_o,
  output logic      [WAYS-1:0]                wr_valid_o,
  output logic      [WAYS-1:0][AGE_W-1:0]     wr_age_o
);

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0]  active;
  logic             found_any;
  logic [WAY_W-1:0] found_idx;
  logic             free_any;
  logic [WAY_W-1:0] free_idx;
  logic             vic_any;
  logic [WAY_W-1:0] vic_idx;
  logic [AGE_W-1:0] vic_age;
  logic [AGE_W-1:0] hit_age;
  logic [WAY_W-1:0] target;

  // Way zero is always in use; ways beyond the array size never exist.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      active[w] = (w == 0) || (5'(w) < {1'b0, ways_cfg_i});
    end
  end

  // First matching way, first free way, and the oldest valid way (lowest index on a tie).
  always_comb begin
    found_any = 1'b0;
    found_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    vic_any   = 1'b0;
    vic_idx   = '0;
    vic_age   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (active[w] && rd_valid_i[w]) begin
        if (!found_any && (rd_tags_i[w] == tag_i)) begin
          found_any = 1'b1;
          found_idx = WAY_W'(w);
        end
        if (!vic_any || (rd_age_i[w] > vic_age)) begin
          vic_any = 1'b1;
          vic_idx = WAY_W'(w);
          vic_age = rd_age_i[w];
        end
      end else if (active[w] && !free_any) begin
        free_any = 1'b1;
        free_idx = WAY_W'(w);
      end
    end
  end

  assign hit_age = rd_age_i[found_idx];

  always_comb begin
    if (found_any) begin
      target = found_idx;
    end else if (free_any) begin
      target = free_idx;
    end else begin
      target = vic_idx;
    end
  end

  // New row: target becomes newest; other valid lines age by one, on a hit younger only.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      wr_tags_o[w]  = rd_tags_i[w];
      wr_valid_o[w] = rd_valid_i[w];
      wr_age_o[w]   = rd_age_i[w];
      if (WAY_W'(w) == target) begin
        wr_age_o[w] = '0;
        if (!found_any) begin
          wr_tags_o[w]  = tag_i;
          wr_valid_o[w] = 1'b1;
        end
      end else if (active[w] && rd_valid_i[w] &&
                   (!found_any || (rd_age_i[w] < hit_age))) begin
        if (rd_age_i[w] != '1) begin
          wr_age_o[w] = rd_age_i[w] + AGE_W'(1);
        end
      end
    end
  end

  assign status_o.hit   = found_any;
  assign status_o.evict = !found_any && !free_any;

endmodule

`default_nettype wire

>>> hw/rtl/salru_chk.sv
// Port-level checker for the cache model, bound to the top level.
`default_nettype none

module salru_chk
  import salru_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire in_t  in_i,
  input wire logic res_valid_o,
  input wire out_t res_o
);

  // Every result is either a hit or a miss, never both.
  a_hit_xor_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.hit != res_o.miss))
    else $error("result is not exactly one of hit and miss");

  // Only a miss can evict.
  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.eviction) |-> res_o.miss)
    else $error("eviction reported on a hit");

  // A valid command transfer makes the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.command == CMD_LOAD || in_i.command == CMD_STORE ||
                        in_i.command == CMD_MODIFY)) |=> busy)
    else $error("accepted command did not raise busy");

  // The first result of a modify is followed at once by a final hit.
  a_modify_second_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |=> (res_valid_o && res_o.last && res_o.hit))
    else $error("second result of a modify missing or not a hit");

  // After the final result of a command the block is free again.
  a_idle_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |-> !busy)
    else $error("block still busy at its final result");

endmodule

bind set_assoc_lru_cache_sim salru_chk u_salru_chk (.*);

`default_nettype wire
